// ----- src/gcd_pkg.sv -----
`timescale 1ns / 1ps

package gcd_pkg;

    localparam int CORDIC_STEPS_DEF = 24;
    localparam int CW      = 33;   // CORDIC x/y/z width, Q30
    localparam int SQ_BITS = 31;   // result bits of each square root

    localparam logic [29:0]          PI_Q28      = 30'd843314857;
    localparam logic signed [CW-1:0] GAIN_Q30    = 33'sh026DD3B6A;
    localparam logic signed [33:0]   ANG_FULL    = 34'sd3019898880;  // 360 deg, Q23
    localparam logic signed [33:0]   ANG_HALF    = 34'sd1509949440;  // 180 deg
    localparam logic signed [33:0]   ANG_QUARTER = 34'sd754974720;   // 90 deg
    localparam logic [59:0]          RAD_RND     = 60'd188743680;    // half of 180 * 2^21
    localparam logic [25:0]          DIV45_M     = 26'd47721859;     // ceil(2^31 / 45)
    localparam logic [5:0]           DIV45_D     = 6'd45;
    localparam logic [13:0]          DIAM_KM     = 14'd12742;
    localparam logic [30:0]          ONE_Q30     = 31'h40000000;

    typedef logic signed [CW-1:0] t_cval;

    function automatic t_cval atan_q30(input logic [4:0] idx);
        t_cval v;
        case (idx)
            5'd0:  v = 33'sh03243F6A8;
            5'd1:  v = 33'sh01DAC6705;
            5'd2:  v = 33'sh00FADBAFC;
            5'd3:  v = 33'sh007F56EA6;
            5'd4:  v = 33'sh003FEAB76;
            5'd5:  v = 33'sh001FFD55B;
            5'd6:  v = 33'sh000FFFAAA;
            5'd7:  v = 33'sh0007FFF55;
            5'd8:  v = 33'sh0003FFFEA;
            5'd9:  v = 33'sh0001FFFFD;
            5'd10: v = 33'sh0000FFFFF;
            5'd11: v = 33'sh00007FFFF;
            5'd12: v = 33'sh00003FFFF;
            5'd13: v = 33'sh00001FFFF;
            5'd14: v = 33'sh00000FFFF;
            5'd15: v = 33'sh000007FFF;
            5'd16: v = 33'sh000003FFF;
            5'd17: v = 33'sh000001FFF;
            5'd18: v = 33'sh000000FFF;
            5'd19: v = 33'sh0000007FF;
            5'd20: v = 33'sh0000003FF;
            5'd21: v = 33'sh0000001FF;
            5'd22: v = 33'sh0000000FF;
            5'd23: v = 33'sh00000007F;
            5'd24: v = 33'sh00000003F;
            5'd25: v = 33'sh00000001F;
            5'd26: v = 33'sh00000000F;
            5'd27: v = 33'sh000000008;
            5'd28: v = 33'sh000000004;
            5'd29: v = 33'sh000000002;
            5'd30: v = 33'sh000000001;
            default: v = '0;
        endcase
        return v;
    endfunction

    // exact floor(x / 45) for x < 2^25
    function automatic logic [19:0] div45(input logic [24:0] x);
        logic [50:0] p;
        p = {26'b0, x} * {25'b0, DIV45_M};
        return p[50:31];
    endfunction

endpackage

// ----- src/gcd_in_if.sv -----
`timescale 1ns / 1ps

interface gcd_in_if;
    logic               valid;
    logic               ready;
    logic signed [29:0] lat_a;
    logic signed [30:0] lon_a;
    logic signed [29:0] lat_b;
    logic signed [30:0] lon_b;

    modport source(output valid, lat_a, lon_a, lat_b, lon_b, input ready);
    modport sink(input valid, lat_a, lon_a, lat_b, lon_b, output ready);
endinterface

// ----- src/gcd_out_if.sv -----
`timescale 1ns / 1ps

interface gcd_out_if;
    logic        valid;
    logic        ready;
    logic [30:0] distance_km;

    modport source(output valid, distance_km, input ready);
    modport sink(input valid, distance_km, output ready);
endinterface

// ----- src/gcd_rot_lane.sv -----
`timescale 1ns / 1ps

// Degree angle (Q23) -> range reduce -> radians -> rotation CORDIC.
module gcd_rot_lane #(
    parameter int STEPS = gcd_pkg::CORDIC_STEPS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic signed [31:0]    i_ang,
    output gcd_pkg::t_cval        o_sin,
    output gcd_pkg::t_cval        o_cos
);
    import gcd_pkg::*;

    logic signed [33:0] r_red;
    logic [29:0]        r_mag;
    logic               r_sgn2, r_nc2;
    logic [59:0]        r_prod;
    logic               r_sgn3, r_nc3;
    logic [12:0]        r_hq;
    logic [5:0]         r_rh;
    logic [18:0]        r_ql;
    logic               r_sgn4, r_nc4;

    t_cval r_x [0:STEPS];
    t_cval r_y [0:STEPS];
    t_cval r_z [0:STEPS];
    logic  r_nc [0:STEPS];

    // stage 1: wrap into (-180, 180]
    logic signed [33:0] n_red;
    always_comb begin
        n_red = 34'(i_ang);
        if (n_red > ANG_HALF) begin
            n_red = n_red - ANG_FULL;
        end
        if (n_red <= -ANG_HALF) begin
            n_red = n_red + ANG_FULL;
        end
    end

    // stage 2: fold into [-90, 90], note cosine sign flip
    logic signed [33:0] fold;
    logic signed [33:0] fabs;
    logic               n_nc;
    always_comb begin
        fold = r_red;
        n_nc = 1'b0;
        if (r_red > ANG_QUARTER) begin
            fold = ANG_HALF - r_red;
            n_nc = 1'b1;
        end else if (r_red < -ANG_QUARTER) begin
            fold = -ANG_HALF - r_red;
            n_nc = 1'b1;
        end
        fabs = fold[33] ? -fold : fold;
    end

    // stage 4: round, /2^23, high digit of /45
    logic [59:0] rsum;
    logic [36:0] q37;
    logic [19:0] hq;
    logic [24:0] rh;
    always_comb begin
        rsum = r_prod + RAD_RND;
        q37  = rsum[59:23];
        hq   = div45(25'(q37[36:19]));
        rh   = 25'(q37[36:19]) - hq[4:0] * 25'(DIV45_D) - {hq[19:5], 5'b0} * 25'(DIV45_D);
    end

    // stage 5: low digit of /45, signed radians
    logic [19:0] lq;
    logic [32:0] radu;
    t_cval       n_z0;
    always_comb begin
        lq   = div45({r_rh, r_ql});
        radu = 33'({r_hq, 19'b0}) + 33'(lq);
        n_z0 = r_sgn4 ? -$signed(radu) : $signed(radu);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_red  <= n_red;
            r_mag  <= fabs[29:0];
            r_sgn2 <= fold[33];
            r_nc2  <= n_nc;
            r_prod <= 60'(r_mag) * 60'(PI_Q28);
            r_sgn3 <= r_sgn2;
            r_nc3  <= r_nc2;
            r_hq   <= hq[12:0];
            r_rh   <= rh[5:0];
            r_ql   <= q37[18:0];
            r_sgn4 <= r_sgn3;
            r_nc4  <= r_nc3;
            r_x[0] <= GAIN_Q30;
            r_y[0] <= '0;
            r_z[0] <= n_z0;
            r_nc[0] <= r_nc4;
        end
    end

    for (genvar k = 0; k < STEPS; k++) begin : g_rot
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_nc[k+1] <= r_nc[k];
                if (!r_z[k][CW-1]) begin
                    r_x[k+1] <= r_x[k] - (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] + (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] - atan_q30(5'(k));
                end else begin
                    r_x[k+1] <= r_x[k] + (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] - (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] + atan_q30(5'(k));
                end
            end
        end
    end

    assign o_sin = r_y[STEPS];
    assign o_cos = r_nc[STEPS] ? -r_x[STEPS] : r_x[STEPS];

endmodule

// ----- src/great_circle_distance.sv -----
`timescale 1ns / 1ps

// Haversine great-circle distance on a 6371 km sphere. Inputs are two points,
// latitude/longitude in signed degrees Q22; output is kilometres Q16. Fully
// pipelined: one item in and one item out per clock unless the output stalls.
// The depth comes from the two CORDIC chains (one stage per iteration), the two
// parallel 31-stage bit-per-stage square roots, and the degree-to-radian front
// end. Any bit pattern is legal on the inputs; angles wrap modulo 360 degrees.
// The whole pipe advances when the output register is empty or being taken, so
// backpressure stalls it with nothing lost or repeated. No state is kept between
// items.
module great_circle_distance #(
    parameter int CORDIC_STEPS = gcd_pkg::CORDIC_STEPS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gcd_in_if.sink    i_in,
    gcd_out_if.source o_out
);
    import gcd_pkg::*;

    localparam int N = 42 + 2 * CORDIC_STEPS;   // pipeline depth

    logic [N-1:0] r_vld;
    logic         en;
    logic         fire;

    // no input taken while in reset
    assign en         = !r_vld[N-1] || o_out.ready;
    assign i_in.ready = en && i_rst_n;
    assign fire       = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[N-2:0], fire};
        end
    end

    // lane angles, degrees Q23: dlat, dlon, 2*lat_a, 2*lat_b
    logic signed [31:0] r_ang [0:3];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ang[0] <= 32'(i_in.lat_b) - 32'(i_in.lat_a);
            r_ang[1] <= 32'(i_in.lon_b) - 32'(i_in.lon_a);
            r_ang[2] <= 32'($signed({i_in.lat_a, 1'b0}));
            r_ang[3] <= 32'($signed({i_in.lat_b, 1'b0}));
        end
    end

    t_cval lane_sin [0:3];
    t_cval lane_cos [0:3];

    for (genvar l = 0; l < 4; l++) begin : g_lane
        gcd_rot_lane #(.STEPS(CORDIC_STEPS)) u_lane (
            .i_clk (i_clk),
            .i_en  (en),
            .i_ang (r_ang[l]),
            .o_sin (lane_sin[l]),
            .o_cos (lane_cos[l])
        );
    end

    // haversine term h = u^2 + ca*cb*v^2, Q30, products floored
    logic signed [65:0] p_u2, p_v2, p_cc;
    logic signed [67:0] p_t;
    logic signed [33:0] r_u2, r_v2, r_cc, r_u2d, r_t;
    logic signed [34:0] hsum;
    logic [30:0]        r_h, r_hc, n_h;

    assign p_u2 = lane_sin[0] * lane_sin[0];
    assign p_v2 = lane_sin[1] * lane_sin[1];
    assign p_cc = lane_cos[2] * lane_cos[3];
    assign p_t  = r_cc * r_v2;
    assign hsum = 35'(r_u2d) + 35'(r_t);

    // arcsine argument clamp to 0..1
    always_comb begin
        if (hsum < 0) begin
            n_h = '0;
        end else if (hsum > 35'(ONE_Q30)) begin
            n_h = ONE_Q30;
        end else begin
            n_h = hsum[30:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_u2  <= p_u2[63:30];
            r_v2  <= p_v2[63:30];
            r_cc  <= p_cc[63:30];
            r_u2d <= r_u2;
            r_t   <= p_t[63:30];
            r_h   <= n_h;
            r_hc  <= ONE_Q30 - n_h;
        end
    end

    // square roots: lane 0 gives s = sqrt(h), lane 1 gives c = sqrt(1 - h)
    logic [61:0] r_srem  [0:1][0:SQ_BITS-1];
    logic [30:0] r_sroot [0:1][0:SQ_BITS-1];
    logic [61:0] sq_n    [0:1];

    assign sq_n[0] = {1'b0, r_h, 30'b0};
    assign sq_n[1] = {1'b0, r_hc, 30'b0};

    for (genvar l = 0; l < 2; l++) begin : g_sq
        for (genvar j = 0; j < SQ_BITS; j++) begin : g_bit
            localparam int K = SQ_BITS - 1 - j;
            logic [61:0] rem_in;
            logic [30:0] root_in;
            logic [61:0] trial;
            if (j == 0) begin : g_first
                assign rem_in  = sq_n[l];
                assign root_in = '0;
            end else begin : g_next
                assign rem_in  = r_srem[l][j-1];
                assign root_in = r_sroot[l][j-1];
            end
            assign trial = ({31'b0, root_in} << (K + 1)) + (62'd1 << (2 * K));
            always_ff @(posedge i_clk) begin
                if (en) begin
                    if (rem_in >= trial) begin
                        r_srem[l][j]  <= rem_in - trial;
                        r_sroot[l][j] <= root_in | (31'd1 << K);
                    end else begin
                        r_srem[l][j]  <= rem_in;
                        r_sroot[l][j] <= root_in;
                    end
                end
            end
        end
    end

    // vectoring CORDIC: z = atan2(s, c) = asin(sqrt(h))
    t_cval r_vx [0:CORDIC_STEPS-1];
    t_cval r_vy [0:CORDIC_STEPS-1];
    t_cval r_vz [0:CORDIC_STEPS-1];

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_vec
        t_cval xi, yi, zi;
        if (k == 0) begin : g_first
            assign xi = t_cval'({2'b0, r_sroot[1][SQ_BITS-1]});
            assign yi = t_cval'({2'b0, r_sroot[0][SQ_BITS-1]});
            assign zi = '0;
        end else begin : g_next
            assign xi = r_vx[k-1];
            assign yi = r_vy[k-1];
            assign zi = r_vz[k-1];
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                if (!yi[CW-1]) begin
                    r_vx[k] <= xi + (yi >>> k);
                    r_vy[k] <= yi - (xi >>> k);
                    r_vz[k] <= zi + atan_q30(5'(k));
                end else begin
                    r_vx[k] <= xi - (yi >>> k);
                    r_vy[k] <= yi + (xi >>> k);
                    r_vz[k] <= zi - atan_q30(5'(k));
                end
            end
        end
    end

    // distance = round(z * 2 * 6371 / 2^14), negative residue gives zero
    logic [31:0] zc;
    logic [45:0] r_dp;
    logic [46:0] dsum;
    logic [30:0] r_dist, n_dist;

    assign zc   = r_vz[CORDIC_STEPS-1][CW-1] ? '0 : r_vz[CORDIC_STEPS-1][31:0];
    assign dsum = 47'(r_dp) + 47'd8192;

    always_comb begin
        if (|dsum[46:45]) begin
            n_dist = '1;
        end else begin
            n_dist = dsum[44:14];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dp   <= 46'(zc) * 46'(DIAM_KM);
            r_dist <= n_dist;
        end
    end

    assign o_out.valid       = r_vld[N-1];
    assign o_out.distance_km = r_dist;

`ifndef SYNTHESIS
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |=> (o_out.valid && $stable(o_out.distance_km)))
        else $error("stalled result changed");

    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> r_vld[0])
        else $error("accepted item not in pipe");
`endif

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

// Self-checking bench for great_circle_distance. Items come from a queue that
// the stimulus block fills; a negedge driver offers them, a posedge monitor
// predicts each accepted query and checks every returned distance in order.
module tb;

    // Sphere diameter and pi in the fixed-point formats the block uses
    localparam longint DIAMETER_KM   = 12742;
    localparam longint PI_Q28_VAL    = 843314857;
    localparam longint UNIT_Q30      = 64'd1 << 30;
    localparam longint GAIN_Q30_VAL  = 64'h26DD3B6A;
    localparam int     ROT_STEPS     = 24;
    localparam int     LAT_MAX       = 377487360;   // 90 deg, Q22
    localparam int     LON_MAX       = 754974720;   // 180 deg, Q22
    localparam int     WATCHDOG_MAX  = 5000;        // idle cycles before giving up
    localparam int     LONG_HOLD     = 600;         // long receiver hold-off

    typedef struct packed {
        logic signed [29:0] lat_a;
        logic signed [30:0] lon_a;
        logic signed [29:0] lat_b;
        logic signed [30:0] lon_b;
    } query_t;

    logic i_clk;
    logic i_rst_n;

    gcd_in_if  q_if ();
    gcd_out_if d_if ();

    great_circle_distance u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (q_if),
        .o_out  (d_if)
    );

    query_t      query_q[$];        // queries waiting to be offered
    logic [30:0] dist_exp_q[$];     // predicted distances, oldest first
    int          n_errors;
    int          idle_pct;          // sender idle chance, percent
    int          stall_pct;         // receiver stall chance, percent
    bit          hold_req;          // asks the receiver for a long hold-off
    int          hold_cnt;
    int          quiet_cycles;
    bit          q_acc;

    longint arctan_tbl[32] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
        64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
        64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
        64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
        64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
        64'h00000001, 64'h00000000
    };

    // Integer square root, floor
    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Rotation CORDIC: sine and cosine (Q30) of an angle in degrees Q23
    function automatic void deg_sincos(input longint ang, output longint sn,
                                       output longint cs);
        longint full, half, quarter, dv, r, m, rad, x, y, z, dx, dy;
        bit     flip;
        full    = 64'd360 << 23;
        half    = 64'd180 << 23;
        quarter = 64'd90 << 23;
        dv      = 64'd180 << 21;
        r       = ang % full;
        flip    = 1'b0;
        if (r > half) r -= full;
        if (r <= -half) r += full;
        // fold into +-90 deg; cosine changes sign
        if (r > quarter) begin
            r = half - r;
            flip = 1'b1;
        end else if (r < -quarter) begin
            r = -half - r;
            flip = 1'b1;
        end
        m   = (r < 0) ? -r : r;
        rad = (m * PI_Q28_VAL + dv / 2) / dv;
        if (r < 0) rad = -rad;
        x = GAIN_Q30_VAL;
        y = 0;
        z = rad;
        for (int i = 0; i < ROT_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= arctan_tbl[i];
            end else begin
                x += dx; y -= dy; z += arctan_tbl[i];
            end
        end
        sn = y;
        cs = flip ? -x : x;
    endfunction

    // Vectoring CORDIC: atan2(y, x) in Q30 radians, x and y not negative
    function automatic longint vec_atan2(input longint y, input longint x);
        longint z, dx, dy;
        z = 0;
        for (int i = 0; i < ROT_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; z += arctan_tbl[i];
            end else begin
                x -= dx; y += dy; z -= arctan_tbl[i];
            end
        end
        return z;
    endfunction

    // Expected distance for one query
    function automatic logic [30:0] haversine_km(input query_t q);
        longint la, oa, lb, ob, u, v, ca, cb, unused, u2, v2, cc, h, s, c, z, d;
        la = q.lat_a;
        oa = q.lon_a;
        lb = q.lat_b;
        ob = q.lon_b;
        // half differences in Q22 read as Q23 are exact
        deg_sincos(lb - la, u, unused);
        deg_sincos(ob - oa, v, unused);
        deg_sincos(la * 2, unused, ca);
        deg_sincos(lb * 2, unused, cb);
        u2 = (u * u) >>> 30;
        v2 = (v * v) >>> 30;
        cc = (ca * cb) >>> 30;
        h  = u2 + ((cc * v2) >>> 30);
        // arcsine argument clamp absorbs rounding overshoot
        if (h < 0) h = 0;
        if (h > UNIT_Q30) h = UNIT_Q30;
        s = longint'(int_sqrt(longint'(h) << 30));
        c = longint'(int_sqrt(longint'(UNIT_Q30 - h) << 30));
        z = vec_atan2(s, c);
        if (z < 0) z = 0;   // tiny negative residue reads as zero distance
        d = (z * DIAMETER_KM + (64'd1 << 13)) >>> 14;
        if (d > 64'h7FFFFFFF) d = 64'h7FFFFFFF;
        return d[30:0];
    endfunction

    function automatic logic signed [29:0] rand_lat(input logic signed [29:0] near);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return 30'($signed($urandom_range(0, 2 * LAT_MAX)) - LAT_MAX);
            5:             return 30'(near + $signed($urandom_range(0, 2000)) - 1000);
            6:             return $urandom_range(0, 1) ? 30'(LAT_MAX) : 30'(-LAT_MAX);
            7:             return -near;
            default:       return 30'($urandom());   // any bit pattern
        endcase
    endfunction

    function automatic logic signed [30:0] rand_lon(input logic signed [30:0] near);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return 31'($signed($urandom_range(0, 2 * LON_MAX)) - LON_MAX);
            5:             return 31'(near + $signed($urandom_range(0, 2000)) - 1000);
            6:             return 31'(near + ($urandom_range(0, 1) ? LON_MAX : -LON_MAX));
            7:             return -near;
            default:       return 31'($urandom());
        endcase
    endfunction

    task automatic add_query(input int la, input int oa, input int lb, input int ob);
        query_t q;
        q.lat_a = 30'(la);
        q.lon_a = 31'(oa);
        q.lat_b = 30'(lb);
        q.lon_b = 31'(ob);
        query_q.insert(query_q.size(), q);
    endtask

    task automatic add_random(input int n);
        query_t q;
        repeat (n) begin
            q.lat_a = rand_lat(0);
            q.lon_a = rand_lon(0);
            q.lat_b = rand_lat(q.lat_a);
            q.lon_b = rand_lon(q.lon_a);
            query_q.insert(query_q.size(), q);
        end
    endtask

    // Wait until every query is offered and taken and every distance is back
    task automatic drain();
        while (query_q.size() != 0 || dist_exp_q.size() != 0 || q_if.valid)
            @(posedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Driver: new query data and valid at the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            q_if.valid <= 1'b0;
        end else if (!(q_if.valid && !q_acc)) begin
            if (query_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                {q_if.lat_a, q_if.lon_a, q_if.lat_b, q_if.lon_b} <= query_q.pop_front();
                q_if.valid <= 1'b1;
            end else begin
                q_if.valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off counted here on request
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            d_if.ready <= 1'b0;
            hold_cnt   <= 0;
        end else if (hold_req && hold_cnt == 0) begin
            hold_cnt   <= LONG_HOLD;
            d_if.ready <= 1'b0;
        end else if (hold_cnt > 1) begin
            hold_cnt   <= hold_cnt - 1;
            d_if.ready <= 1'b0;
        end else begin
            if (hold_cnt == 1 && !hold_req) hold_cnt <= 0;
            d_if.ready <= (hold_cnt == 0) && ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Monitor: predict on query acceptance, check on distance acceptance
    always @(posedge i_clk) begin
        logic [30:0] want;
        q_acc = i_rst_n && q_if.valid && q_if.ready;
        if (q_acc)
            dist_exp_q.insert(dist_exp_q.size(),
                              haversine_km({q_if.lat_a, q_if.lon_a,
                                            q_if.lat_b, q_if.lon_b}));
        if (i_rst_n && d_if.valid && d_if.ready) begin
            if (dist_exp_q.size() == 0) begin
                $display("%0t: unexpected distance %0d", $time, d_if.distance_km);
                n_errors++;
            end else begin
                want = dist_exp_q.pop_front();
                if (d_if.distance_km !== want) begin
                    $display("%0t: distance_km expected %0d actual %0d",
                             $time, want, d_if.distance_km);
                    n_errors++;
                end
            end
        end
        // watchdog on cycles where neither side moves
        if (q_acc || (d_if.valid && d_if.ready) || !i_rst_n)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_MAX) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        n_errors     = 0;
        idle_pct     = 0;
        stall_pct    = 0;
        hold_req     = 1'b0;
        quiet_cycles = 0;
        q_if.valid   = 1'b0;
        q_if.lat_a   = '0;
        q_if.lon_a   = '0;
        q_if.lat_b   = '0;
        q_if.lon_b   = '0;
        d_if.ready   = 1'b0;
        i_rst_n      = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: same point, poles, antipodes, dateline, extremes
        add_query(0, 0, 0, 0);
        add_query(LAT_MAX, 0, -LAT_MAX, 0);
        add_query(0, 0, 0, LON_MAX);
        add_query(0, -LON_MAX, 0, LON_MAX);
        add_query(0, LON_MAX - 4, 0, -LON_MAX + 4);
        add_query(LAT_MAX, LON_MAX, LAT_MAX, -LON_MAX);
        add_query(-LAT_MAX, 0, -LAT_MAX, 12345678);
        add_query(1, 0, 0, 1);
        add_query(LAT_MAX / 2, LON_MAX / 2, -LAT_MAX / 2, -LON_MAX / 2);
        add_query(123456789, -98765432, 123456789, -98765432);
        add_query(123456789, -98765432, 123456790, -98765431);
        // bit patterns beyond the legal ranges wrap modulo 360 deg
        add_query(32'h1FFFFFFF, 32'h3FFFFFFF, 32'h20000000, 32'h40000000);
        add_query(32'h20000000, 32'h40000000, 32'h1FFFFFFF, 32'h3FFFFFFF);
        add_query(-1, -1, 0, 0);
        add_query(2 * LAT_MAX, 0, 0, 0);
        add_query(0, 0, 4 * LAT_MAX, 4 * LON_MAX / 2);
        add_query(32'h2AAAAAAA, 32'h55555555, 32'h15555555, 32'h2AAAAAAA);
        add_query(LAT_MAX, 0, LAT_MAX - 1, 0);
        drain();

        // Random phases with different idling and stalling
        add_random(150);
        drain();
        idle_pct = 60;
        add_random(120);
        drain();
        idle_pct  = 0;
        stall_pct = 60;
        add_random(120);
        drain();
        idle_pct = 10;
        stall_pct = 10;
        add_random(100);
        drain();

        // Long receiver hold-off while queries keep coming; pipe fills up
        idle_pct  = 0;
        stall_pct = 0;
        hold_req  = 1'b1;
        add_random(150);
        repeat (LONG_HOLD / 2) @(posedge i_clk);
        hold_req = 1'b0;
        drain();

        repeat (200) @(posedge i_clk);
        if (n_errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
